[hdl/assert_macros.svh]
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Plain check without reset qualifier
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hdl/acache_pkg.sv]
// ----------------------------------------------------------------------------
// acache_pkg
// Shared types and constants for the associative cache.
// ----------------------------------------------------------------------------
package acache_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CNT_W = 32;
    localparam int STAMP_W = 40;
    localparam logic POLICY_LFU = 1'b1;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic shift_step;
        logic do_hit;
        logic do_insert;
        logic evict_drop;
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic hit;
        logic full;
        logic scan_last;
        logic shift_last;
    } sts_t;
endpackage

[hdl/acache_if.sv]
// ----------------------------------------------------------------------------
// acache_req_if / acache_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface acache_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] key;
    logic [63:0] value;
    modport source (output valid, opcode, key, value, input ready);
    modport sink (input valid, opcode, key, value, output ready);
endinterface

interface acache_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [63:0] hit_value;
    logic        evicted;
    modport source (output valid, hit, hit_value, evicted, input ready);
    modport sink (input valid, hit, hit_value, evicted, output ready);
endinterface

[hdl/assoc_cache_lfu_lru.sv]
// ----------------------------------------------------------------------------
// assoc_cache_lfu_lru
// Fully associative key/value cache with LRU or LFU replacement.
//
// channel  dir  fields
// req      in   opcode, key, value
// rsp      out  hit, hit_value, evicted
// cfg      in   cfg_we, cfg_wdata (replace_policy)
//
// Lookup: search, then response; insert with room: search, write, then response.
// Insert into a full cache: search, victim scan, shift, write, then response.
// One item at a time; req is refused until the response transfers.
// Reset empties the cache and clears the access clock; no clearing pass.
// ----------------------------------------------------------------------------
module assoc_cache_lfu_lru
    import acache_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    acache_req_if.sink   req,
    acache_rsp_if.source rsp,
    input  logic cfg_we,
    input  logic cfg_wdata
);
    logic policy_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) policy_reg <= 1'b0;
        else if (cfg_we) policy_reg <= cfg_wdata;
    end

    acache_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .sts(sts), .cmd(cmd)
    );

    acache_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .policy(policy_reg),
        .in_opcode(req.opcode), .in_key(req.key), .in_value(req.value),
        .cmd(cmd), .sts(sts),
        .hit(rsp.hit), .hit_value(rsp.hit_value), .evicted(rsp.evicted)
    );
endmodule

[hdl/acache_ctrl.sv]
// ----------------------------------------------------------------------------
// acache_ctrl
// Sequencer for lookup, victim scan, shift and insert.
// ----------------------------------------------------------------------------
module acache_ctrl
    import acache_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (!sts.is_insert) state_next = ST_DONE;
                else if (sts.full) state_next = ST_SCAN;
                else state_next = ST_WRITE;
            end
            ST_SCAN:   if (sts.scan_last) state_next = ST_SHIFT;
            ST_SHIFT:  if (sts.shift_last) state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_DONE;
            ST_DONE:   if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SEARCH:
            begin
                cmd.do_hit = !sts.is_insert && sts.hit;
                cmd.scan_start = sts.is_insert && sts.full;
            end
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                cmd.evict_drop = sts.shift_last;
            end
            ST_WRITE:  cmd.do_insert = 1'b1;
            ST_DONE:   out_valid = 1'b1;
            default:   cmd = '0;
        endcase
    end
endmodule

[hdl/acache_dp.sv]
// ----------------------------------------------------------------------------
// acache_dp
// Entry storage, key match, victim scan and shift datapath.
// ----------------------------------------------------------------------------
module acache_dp
    import acache_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              policy,
    input  logic              in_opcode,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [VAL_W-1:0]  in_value,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              hit,
    output logic [VAL_W-1:0]  hit_value,
    output logic              evicted
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0]   key_mem   [CAPACITY];
    logic [VAL_W-1:0]   val_mem   [CAPACITY];
    logic [CNT_W-1:0]   cnt_mem   [CAPACITY];
    logic [STAMP_W-1:0] stamp_mem [CAPACITY];

    logic [FW-1:0]      fill_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               hit_reg;
    logic [VAL_W-1:0]   hit_value_reg;
    logic               evicted_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      vic_reg;
    logic [CNT_W-1:0]   vcnt_reg;
    logic [STAMP_W-1:0] vstamp_reg;

    logic [CAPACITY-1:0] match;
    logic                any_hit;
    logic [IW-1:0]       hit_idx;
    logic                better;
    logic [IW-1:0]       wr_idx;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (FW'(i) < fill_reg) && (key_mem[i] == key_reg);
        end
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                any_hit = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        if (policy == POLICY_LFU) better = cnt_mem[idx_reg] < vcnt_reg;
        else better = stamp_mem[idx_reg] < vstamp_reg;
    end

    assign wr_idx = IW'(fill_reg);
    assign sts.is_insert = op_reg;
    assign sts.hit = any_hit;
    assign sts.full = (fill_reg == FW'(CAPACITY));
    assign sts.scan_last = (idx_reg == IW'(CAPACITY - 1));
    assign sts.shift_last = (FW'(idx_reg) + FW'(1) >= fill_reg);
    assign hit = hit_reg;
    assign hit_value = hit_value_reg;
    assign evicted = evicted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            clock_reg <= '0;
        end
        else
        begin
            if (cmd.do_hit || cmd.do_insert)
            begin
                if (clock_reg != '1) clock_reg <= clock_reg + STAMP_W'(1);
            end
            if (cmd.do_insert) fill_reg <= fill_reg + FW'(1);
            else if (cmd.evict_drop) fill_reg <= fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_opcode;
            key_reg <= in_key;
            val_reg <= in_value;
            hit_reg <= 1'b0;
            hit_value_reg <= '0;
            evicted_reg <= 1'b0;
        end
        if (cmd.do_hit)
        begin
            hit_reg <= 1'b1;
            hit_value_reg <= val_mem[hit_idx];
            if (cnt_mem[hit_idx] != '1) cnt_mem[hit_idx] <= cnt_mem[hit_idx] + CNT_W'(1);
            stamp_mem[hit_idx] <= clock_reg;
        end
        if (cmd.scan_start)
        begin
            vic_reg <= '0;
            vcnt_reg <= cnt_mem[0];
            vstamp_reg <= stamp_mem[0];
            idx_reg <= (CAPACITY > 1) ? IW'(1) : '0;
            evicted_reg <= 1'b1;
        end
        if (cmd.scan_step)
        begin
            if (better)
            begin
                vic_reg <= idx_reg;
                vcnt_reg <= cnt_mem[idx_reg];
                vstamp_reg <= stamp_mem[idx_reg];
            end
            if (sts.scan_last)
            begin
                idx_reg <= better ? idx_reg : vic_reg;
            end
            else
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
        if (cmd.shift_step && !sts.shift_last)
        begin
            key_mem[idx_reg] <= key_mem[idx_reg + IW'(1)];
            val_mem[idx_reg] <= val_mem[idx_reg + IW'(1)];
            cnt_mem[idx_reg] <= cnt_mem[idx_reg + IW'(1)];
            stamp_mem[idx_reg] <= stamp_mem[idx_reg + IW'(1)];
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.do_insert)
        begin
            key_mem[wr_idx] <= key_reg;
            val_mem[wr_idx] <= val_reg;
            cnt_mem[wr_idx] <= CNT_W'(1);
            stamp_mem[wr_idx] <= clock_reg;
        end
    end
endmodule

[hdl/acache_checker.sv]
// ----------------------------------------------------------------------------
// acache_checker
// Port-level checks on the cache channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module acache_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_hit,
    input logic rsp_evicted,
    input logic [63:0] rsp_hit_value
);
    `ASSERT_IMPL(a_excl, clk, rst_n, !(req_ready && rsp_valid), "ready while response pending")
    `ASSERT_IMPL(a_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
    `ASSERT_IMPL(a_kind, clk, rst_n, rsp_valid |-> !(rsp_hit && rsp_evicted), "hit and evict")
    `ASSERT_IMPL(a_miss, clk, rst_n, rsp_valid && !rsp_hit |-> rsp_hit_value == 64'd0, "miss value")
endmodule

bind assoc_cache_lfu_lru acache_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_hit(rsp.hit), .rsp_evicted(rsp.evicted), .rsp_hit_value(rsp.hit_value)
);
